/* design/sha512_pkg.sv */
package sha512_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [7:0] work_t;

  localparam int unsigned Rounds        = 80;
  localparam int unsigned WordsPerBlock = 16;
  localparam int unsigned DigestWords   = 8;

  localparam word_t INIT_CHAIN [DigestWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t ROUND_K [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
  endfunction

endpackage

/* design/sha512_round.sv */
module sha512_round (
  input  sha512_pkg::work_t cur,
  input  sha512_pkg::word_t w,
  input  sha512_pkg::word_t k,
  output sha512_pkg::work_t nxt
);

  sha512_pkg::word_t ch;
  sha512_pkg::word_t maj;
  sha512_pkg::word_t t1;
  sha512_pkg::word_t t2;

  always_comb begin
    ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    t1  = cur[7] + sha512_pkg::big_sigma1(cur[4]) + ch + k + w;
    t2  = sha512_pkg::big_sigma0(cur[0]) + maj;
    nxt[7] = cur[6];
    nxt[6] = cur[5];
    nxt[5] = cur[4];
    nxt[4] = cur[3] + t1;
    nxt[3] = cur[2];
    nxt[2] = cur[1];
    nxt[1] = cur[0];
    nxt[0] = t1 + t2;
  end

endmodule

/* design/sha512_compression.sv */
// channel  | direction | handshake           | payload
// message  | in        | in_valid / in_stall | message_word, new_message, final_block
// digest   | out       | out_valid/out_stall | digest_word, digest_index, digest_last
//
// One word per cycle is taken for the first fifteen words of a block.
// The sixteenth word starts 80 rounds on the shared round unit (one a cycle),
// then ST_FINISH adds the working state into the chain.
// A final block adds eight digest transfers, one per cycle while out_stall is low.
// rst is synchronous: chain reloads the initial values, word count and round clear.
// in_stall is high in every state but idle: rounds, chain update and digest send.
module sha512_compression (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha512_pkg::word_t   message_word,
  input  logic                new_message,
  input  logic                final_block,
  output logic                out_valid,
  input  logic                out_stall,
  output sha512_pkg::word_t   digest_word,
  output logic [2:0]          digest_index,
  output logic                digest_last
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam int unsigned RoundW = $clog2(sha512_pkg::Rounds);
  localparam int unsigned PosW   = $clog2(sha512_pkg::WordsPerBlock);
  localparam logic [RoundW-1:0] LastRound = RoundW'(sha512_pkg::Rounds - 1);
  localparam logic [PosW-1:0]   LastPos   = PosW'(sha512_pkg::WordsPerBlock - 1);

  logic [1:0]            state;
  logic [RoundW-1:0]     round;
  logic [PosW-1:0]       pos;
  logic [PosW-1:0]       pos_eff;
  logic [2:0]            out_idx;
  logic                  final_reg;
  sha512_pkg::work_t     chain;
  sha512_pkg::work_t     work;
  sha512_pkg::work_t     round_out;
  sha512_pkg::work_t     chain_src;
  sha512_pkg::word_t     win [sha512_pkg::WordsPerBlock];
  sha512_pkg::word_t     sched_new;
  logic                  in_xfer;
  logic                  out_xfer;

  sha512_round u_round (
    .cur (work),
    .w   (win[0]),
    .k   (sha512_pkg::ROUND_K[round]),
    .nxt (round_out)
  );

  always_comb begin
    sched_new = sha512_pkg::small_sigma1(win[14]) + win[9]
              + sha512_pkg::small_sigma0(win[1]) + win[0];
    pos_eff   = new_message ? '0 : pos;
    for (int i = 0; i < 8; i++) begin
      chain_src[i] = new_message ? sha512_pkg::INIT_CHAIN[i] : chain[i];
    end
  end

  assign in_stall     = (state != ST_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_valid    = (state == ST_OUT);
  assign out_xfer     = out_valid && !out_stall;
  assign digest_word  = chain[0];
  assign digest_index = out_idx;
  assign digest_last  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      round   <= '0;
      pos     <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha512_pkg::INIT_CHAIN[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            chain <= chain_src;
            pos   <= pos_eff + 1'b1;
            if (pos_eff == LastPos) begin
              work      <= chain_src;
              final_reg <= final_block;
              round     <= '0;
              state     <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          work <= round_out;
          if (round == LastRound) begin
            round <= '0;
            state <= ST_FINISH;
          end else begin
            round <= round + 1'b1;
          end
        end
        ST_FINISH: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          out_idx <= '0;
          state   <= final_reg ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (out_xfer) begin
            // rotate; eight transfers leave the chain as it was
            for (int i = 0; i < 7; i++) begin
              chain[i] <= chain[i+1];
            end
            chain[7] <= chain[0];
            out_idx  <= out_idx + 1'b1;
            if (digest_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer || state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= (state == ST_ROUND) ? sched_new : message_word;
    end
  end

  a_start_rounds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && pos_eff == LastPos) |=> (state == ST_ROUND && round == '0))
    else $error("block did not start rounds after its last word");

  a_out_round_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (round == '0 && in_stall))
    else $error("digest shown while rounds active or input open");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && digest_last) |=> (state == ST_IDLE && !out_valid))
    else $error("digest continued past its last word");

  a_finish_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(state) == ST_ROUND && $past(round) == LastRound))
    else $error("chain update without full round sequence");

endmodule

/* tb/sv/sha512_compression_tb.sv */
module sha512_compression_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned TailCycles = 120;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    sha512_pkg::word_t word;
    logic [2:0]        index;
    logic              last;
  } digest_entry_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  sha512_pkg::word_t message_word;
  logic              new_message;
  logic              final_block;
  logic              out_valid;
  logic              out_stall;
  sha512_pkg::word_t digest_word;
  logic [2:0]        digest_index;
  logic              digest_last;

  digest_entry_t     digest_q[$];
  sha512_pkg::word_t chain_state [8];
  sha512_pkg::word_t sched_window [16];
  int unsigned       word_pos;
  int unsigned       items_sent;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  int unsigned       stall_left;
  int unsigned       calm_left;
  bit                steady;

  sha512_compression dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .message_word (message_word),
    .new_message  (new_message),
    .final_block  (final_block),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .digest_index (digest_index),
    .digest_last  (digest_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic sha512_pkg::word_t ror64(input sha512_pkg::word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sha512_pkg::word_t rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic compress_chain();
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t t1;
    sha512_pkg::word_t t2;
    sha512_pkg::word_t w;
    for (int i = 0; i < 8; i++) v[i] = chain_state[i];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w = sched_window[(t + 14) % 16];
        t1 = ror64(w, 19) ^ ror64(w, 61) ^ (w >> 6);
        w = sched_window[(t + 1) % 16];
        t2 = ror64(w, 1) ^ ror64(w, 8) ^ (w >> 7);
        sched_window[t % 16] = t1 + sched_window[(t + 9) % 16] + t2 + sched_window[t % 16];
      end
      w = sched_window[t % 16];
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::ROUND_K[t] + w;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_state[i] = chain_state[i] + v[i];
  endtask

  task automatic predict_digest(input sha512_pkg::word_t w, input bit nm, input bit fb);
    digest_entry_t e;
    if (nm) begin
      chain_state = sha512_pkg::INIT_CHAIN;
      word_pos = 0;
    end
    sched_window[word_pos] = w;
    word_pos = (word_pos + 1) % 16;
    if (word_pos != 0) return;
    compress_chain();
    if (!fb) return;
    for (int k = 0; k < 8; k++) begin
      e.word = chain_state[k];
      e.index = k[2:0];
      e.last = (k == 7);
      digest_q.push_back(e);
    end
  endtask

  task automatic send_word(input sha512_pkg::word_t w, input bit nm, input bit fb);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    message_word <= w;
    new_message <= nm;
    final_block <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(w, nm, fb);
    items_sent++;
  endtask

  // receiver side: random stall, then check each transfer against the oldest entry
  always @(posedge clk) begin
    digest_entry_t e;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected digest transfer: word %h index %0d last %b",
                   digest_word, digest_index, digest_last);
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word || digest_index !== e.index || digest_last !== e.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     e.word, e.index, e.last, digest_word, digest_index, digest_last);
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 149) == 0) begin
      calm_left <= $urandom_range(50, 300);
      out_stall <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_partial_block();
    send_word('1, 1'b1, 1'b0);
    send_word('0, 1'b0, 1'b0);
    send_word('1, 1'b0, 1'b1);
    send_word(64'h8000_0000_0000_0001, 1'b0, 1'b0);
  endtask

  // restart mid-block, final flag on every word, all-zero and all-one words
  task automatic test_extreme_block();
    for (int i = 0; i < 16; i++)
      send_word((i % 2) ? '1 : '0, i == 0, 1'b1);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 16; i++)
      send_word(rand_word(), i == 0, i == 15);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic test_random_messages(input int unsigned target);
    int unsigned r;
    int unsigned nblocks;
    int unsigned n;
    bit          nm;
    bit          fb;
    bit          closes;
    bit          restarts;
    while (items_sent < target) begin
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        nblocks = $urandom_range(1, 3);
        closes = ($urandom_range(0, 9) != 0);
        restarts = ($urandom_range(0, 6) != 0);
        for (int b = 0; b < nblocks; b++) begin
          for (int i = 0; i < 16; i++) begin
            nm = (b == 0 && i == 0) ? restarts : 1'b0;
            if (i == 15)
              fb = (b == nblocks - 1) ? closes : 1'b0;
            else
              fb = ($urandom_range(0, 3) == 0);
            send_word(rand_word(), nm, fb);
          end
        end
      end else if (r < 85) begin
        n = $urandom_range(1, 15);
        for (int i = 0; i < n; i++)
          send_word(rand_word(), i == 0, $urandom_range(0, 1) == 1);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_word(rand_word(), $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    message_word <= '0;
    new_message <= 1'b0;
    final_block <= 1'b0;
    steady = 1'b0;
    items_sent = 0;
    chain_state = sha512_pkg::INIT_CHAIN;
    word_pos = 0;
    for (int i = 0; i < 16; i++) sched_window[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_partial_block();
    test_extreme_block();
    test_random_messages(items_sent + RandomItems / 2);
    test_drain_pause();
    test_random_messages(items_sent + RandomItems / 2);

    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sha512_pkg.sv
design/sha512_round.sv
design/sha512_compression.sv
tb/sv/sha512_compression_tb.sv
